// ----- hdl/hkm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hkm_pkg: shared types and constants of the heap k-way merge
// Sizes, heap entry layout, register decode and controller/datapath buses.
// ----------------------------------------------------------------------------
package hkm_pkg;

    localparam int MAX_SOURCES = 16;
    localparam int KEY_BITS    = 32;
    localparam int FIELD_W     = 32;
    localparam int SRC_W       = 4;
    localparam int NS_W        = 5;
    localparam int IDX_W       = $clog2(MAX_SOURCES);
    localparam int CNT_W       = $clog2(MAX_SOURCES + 1);
    localparam int CH_W        = IDX_W + 2;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    localparam logic            REG_NUM_SOURCES = 1'b0;
    localparam logic [NS_W-1:0] NS_RESET        = NS_W'(16);

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [FIELD_W-1:0]  value;
        logic [SRC_W-1:0]    src;
    } t_entry;

    typedef struct packed {
        logic load;
        logic book;
        logic up_first;
        logic up_step;
        logic pop_first;
        logic pop_load;
        logic dn_step;
    } t_dp_cmd;

    typedef struct packed {
        logic ins;
        logic emit_now;
        logic emit;
        logic pos_zero;
        logic up_less;
        logic up_zero;
        logic heap_empty;
        logic dn_stop;
    } t_dp_stat;

endpackage
`default_nettype wire

// ----- hdl/hkm_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hkm_datapath: heap memory, counters and result registers
// Performs insert sift-up and pop sift-down steps as commanded.
// ----------------------------------------------------------------------------
module hkm_datapath (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire hkm_pkg::t_dp_cmd            i_cmd,
    output hkm_pkg::t_dp_stat                o_stat,
    input  wire logic [hkm_pkg::NS_W-1:0]    i_num_sources,
    input  wire logic [hkm_pkg::SRC_W-1:0]   i_source_id,
    input  wire logic [hkm_pkg::FIELD_W-1:0] i_dest_key,
    input  wire logic [hkm_pkg::FIELD_W-1:0] i_src_value,
    input  wire logic                        i_stream_empty,
    output logic                             o_result_strobe,
    output logic                             o_edge_valid,
    output logic [hkm_pkg::FIELD_W-1:0]      o_out_key,
    output logic [hkm_pkg::FIELD_W-1:0]      o_out_value,
    output logic [hkm_pkg::SRC_W-1:0]        o_refill_source,
    output logic                             o_merge_done
);
    import hkm_pkg::*;

    t_entry             r_mem [MAX_SOURCES];
    t_entry             r_item;
    logic               r_item_empty;
    t_entry             r_rd_a;
    t_entry             r_rd_b;
    logic [IDX_W-1:0]   r_pos;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_fill;
    logic               r_filling;
    logic               r_emit;
    logic               r_strobe;
    logic               r_edge_valid;
    logic [FIELD_W-1:0] r_out_key;
    logic [FIELD_W-1:0] r_out_value;
    logic [SRC_W-1:0]   r_refill_source;
    logic               r_merge_done;

    logic [CNT_W-1:0]   eff;
    logic [CNT_W-1:0]   fill_next;
    logic               ins;
    logic               emit_now;
    logic [IDX_W-1:0]   up;
    logic [IDX_W-1:0]   up2;
    logic               up_less;
    logic [CH_W-1:0]    l_ch;
    logic [CH_W-1:0]    r_ch;
    logic               take_l;
    logic               take_r;
    logic               dn_stop;
    logic [KEY_BITS-1:0] small_key;
    t_entry             child;
    logic [IDX_W-1:0]   s_idx;
    logic [CH_W-1:0]    ls;
    logic [CH_W-1:0]    rs;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr_a;
    logic [IDX_W-1:0]   rd_addr_b;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    t_entry             wr_data;

    // A register value of zero counts as one stream; values above the heap
    // size are held at the heap size.
    always_comb begin
        if (i_num_sources == '0) begin
            eff = CNT_W'(1);
        end else if (int'(i_num_sources) > MAX_SOURCES) begin
            eff = CNT_W'(MAX_SOURCES);
        end else begin
            eff = CNT_W'(i_num_sources);
        end
    end

    assign fill_next = (r_fill < CNT_W'(MAX_SOURCES)) ? r_fill + 1'b1 : r_fill;
    assign ins       = !r_item_empty && (r_count < CNT_W'(MAX_SOURCES));
    assign emit_now  = r_filling ? (fill_next >= eff) : 1'b1;

    assign up      = IDX_W'((r_pos - 1'b1) >> 1);
    assign up2     = IDX_W'((up - 1'b1) >> 1);
    assign up_less = r_item.key < r_rd_a.key;

    // Sift-down: the moving entry is held in r_item rather than in memory,
    // so each level is one compare of both children against it.
    assign l_ch      = {1'b0, r_pos, 1'b1};
    assign r_ch      = l_ch + 1'b1;
    assign take_l    = (l_ch < CH_W'(r_count)) && (r_rd_a.key < r_item.key);
    assign small_key = take_l ? r_rd_a.key : r_item.key;
    assign take_r    = (r_ch < CH_W'(r_count)) && (r_rd_b.key < small_key);
    assign dn_stop   = !take_l && !take_r;
    assign child     = take_r ? r_rd_b : r_rd_a;
    assign s_idx     = take_r ? IDX_W'(r_ch) : IDX_W'(l_ch);
    assign ls        = {1'b0, s_idx, 1'b1};
    assign rs        = ls + 1'b1;

    always_comb begin
        rd_en     = 1'b0;
        rd_addr_a = '0;
        rd_addr_b = '0;
        wr_en     = 1'b0;
        wr_addr   = r_pos;
        wr_data   = r_item;
        if (i_cmd.up_first) begin
            if (r_pos == '0) begin
                wr_en = 1'b1;
            end else begin
                rd_en     = 1'b1;
                rd_addr_a = up;
            end
        end
        if (i_cmd.up_step) begin
            wr_en = 1'b1;
            if (up_less) begin
                wr_data = r_rd_a;
                if (up != '0) begin
                    rd_en     = 1'b1;
                    rd_addr_a = up2;
                end
            end
        end
        if (i_cmd.pop_first && (r_count != '0)) begin
            rd_en     = 1'b1;
            rd_addr_a = '0;
            rd_addr_b = IDX_W'(r_count - 1'b1);
        end
        if (i_cmd.pop_load) begin
            rd_en     = 1'b1;
            rd_addr_a = IDX_W'(1);
            rd_addr_b = IDX_W'(2);
        end
        if (i_cmd.dn_step) begin
            wr_en = 1'b1;
            if (!dn_stop) begin
                wr_data   = child;
                rd_en     = 1'b1;
                rd_addr_a = IDX_W'(ls);
                rd_addr_b = IDX_W'(rs);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_a <= r_mem[rd_addr_a];
            r_rd_b <= r_mem[rd_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_fill    <= '0;
            r_filling <= 1'b1;
            r_emit    <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_strobe <= (i_cmd.pop_first && (r_count == '0)) || i_cmd.pop_load;
            if (i_cmd.book) begin
                if (r_filling) begin
                    r_fill <= fill_next;
                    if (fill_next >= eff) begin
                        r_filling <= 1'b0;
                    end
                end
                r_emit <= emit_now;
                if (ins) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.pop_first && (r_count != '0)) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item.key   <= i_dest_key[KEY_BITS-1:0];
            r_item.value <= i_src_value;
            r_item.src   <= i_source_id;
            r_item_empty <= i_stream_empty;
        end
        if (i_cmd.book && ins) begin
            r_pos <= IDX_W'(r_count);
        end
        if (i_cmd.up_step && up_less) begin
            r_pos <= up;
        end
        if (i_cmd.pop_first && (r_count == '0)) begin
            r_edge_valid    <= 1'b0;
            r_out_key       <= '0;
            r_out_value     <= '0;
            r_refill_source <= '0;
            r_merge_done    <= 1'b1;
        end
        if (i_cmd.pop_load) begin
            r_item          <= r_rd_b;
            r_pos           <= '0;
            r_edge_valid    <= 1'b1;
            r_out_key       <= FIELD_W'(r_rd_a.key);
            r_out_value     <= r_rd_a.value;
            r_refill_source <= r_rd_a.src;
            r_merge_done    <= 1'b0;
        end
        if (i_cmd.dn_step && !dn_stop) begin
            r_pos <= s_idx;
        end
    end

    assign o_stat.ins        = ins;
    assign o_stat.emit_now   = emit_now;
    assign o_stat.emit       = r_emit;
    assign o_stat.pos_zero   = (r_pos == '0);
    assign o_stat.up_less    = up_less;
    assign o_stat.up_zero    = (up == '0);
    assign o_stat.heap_empty = (r_count == '0);
    assign o_stat.dn_stop    = dn_stop;

    assign o_result_strobe = r_strobe;
    assign o_edge_valid    = r_edge_valid;
    assign o_out_key       = r_out_key;
    assign o_out_value     = r_out_value;
    assign o_refill_source = r_refill_source;
    assign o_merge_done    = r_merge_done;

endmodule
`default_nettype wire

// ----- hdl/hkm_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hkm_ctrl: sequencer of the heap k-way merge
// Steps one item through bookkeeping, sift-up, pop and sift-down.
// ----------------------------------------------------------------------------
module hkm_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire hkm_pkg::t_dp_stat i_stat,
    output hkm_pkg::t_dp_cmd       o_cmd,
    output logic                   o_busy
);
    import hkm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BOOK,
        S_UP_FIRST,
        S_UP_STEP,
        S_POP_FIRST,
        S_POP_LOAD,
        S_DN_STEP
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   n_busy;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_BOOK;
                end
            end
            S_BOOK: begin
                if (i_stat.ins) begin
                    n_state = S_UP_FIRST;
                end else if (i_stat.emit_now) begin
                    n_state = S_POP_FIRST;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_UP_FIRST: begin
                if (!i_stat.pos_zero) begin
                    n_state = S_UP_STEP;
                end else if (i_stat.emit) begin
                    n_state = S_POP_FIRST;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_UP_STEP: begin
                // Reaching the root leaves the final write to S_UP_FIRST.
                if (i_stat.up_less) begin
                    if (i_stat.up_zero) begin
                        n_state = S_UP_FIRST;
                    end
                end else if (i_stat.emit) begin
                    n_state = S_POP_FIRST;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_POP_FIRST: begin
                n_state = i_stat.heap_empty ? S_IDLE : S_POP_LOAD;
            end
            S_POP_LOAD: begin
                n_state = i_stat.heap_empty ? S_IDLE : S_DN_STEP;
            end
            S_DN_STEP: begin
                if (i_stat.dn_stop) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_busy = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign o_cmd.load      = (r_state == S_IDLE) && i_start;
    assign o_cmd.book      = (r_state == S_BOOK);
    assign o_cmd.up_first  = (r_state == S_UP_FIRST);
    assign o_cmd.up_step   = (r_state == S_UP_STEP);
    assign o_cmd.pop_first = (r_state == S_POP_FIRST);
    assign o_cmd.pop_load  = (r_state == S_POP_LOAD);
    assign o_cmd.dn_step   = (r_state == S_DN_STEP);
    assign o_busy          = r_busy;

endmodule
`default_nettype wire

// ----- hdl/heap_k_way_merge.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// heap_k_way_merge: k-way merge of sorted edge streams on a binary min-heap
// Configuration register, controller and heap datapath.
// ----------------------------------------------------------------------------
// Usage: an edge (or an end-of-stream mark) is transferred by raising start
// while busy is low. The first num_sources transfers fill the heap and only the
// last gives a result; after that each transfer gives one: the smallest edge,
// whose stream is to be refilled next, or a done mark once the heap is empty.
// A result is shown for a single cycle with o_result_strobe high; the receiver
// must take it then, as there is no back-pressure.
// Busy is high after a transfer until the item is through bookkeeping, sift-up
// and any pop and sift-down, so a new transfer waits for the last one; the
// time is set by the sift-up and sift-down loops, one heap level per cycle
// against a memory with registered two-port reads; each pop adds root and
// last-entry reads. Register num_sources lies at byte address 0 of the
// APB-style port; the user must write it only while busy is low; the block
// does not enforce it. Reset, synchronous and active low, empties the heap,
// restarts the fill phase and sets num_sources to 16.
// ----------------------------------------------------------------------------
module heap_k_way_merge (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [hkm_pkg::SRC_W-1:0]   i_source_id,
    input  wire logic [hkm_pkg::FIELD_W-1:0] i_dest_key,
    input  wire logic [hkm_pkg::FIELD_W-1:0] i_src_value,
    input  wire logic                        i_stream_empty,
    output logic                             o_result_strobe,
    output logic                             o_edge_valid,
    output logic [hkm_pkg::FIELD_W-1:0]      o_out_key,
    output logic [hkm_pkg::FIELD_W-1:0]      o_out_value,
    output logic [hkm_pkg::SRC_W-1:0]        o_refill_source,
    output logic                             o_merge_done,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [hkm_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [hkm_pkg::DATA_W-1:0]  pwdata,
    output logic [hkm_pkg::DATA_W-1:0]       prdata,
    output logic                             pready
);
    import hkm_pkg::*;

    logic [NS_W-1:0] r_num_sources;
    logic            reg_hit;
    t_dp_cmd         cmd;
    t_dp_stat        stat;

    assign reg_hit = (paddr[ADDR_W-1] == REG_NUM_SOURCES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_sources <= NS_RESET;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_num_sources <= pwdata[NS_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = reg_hit ? DATA_W'(r_num_sources) : '0;

    hkm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    hkm_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_num_sources   (r_num_sources),
        .i_source_id     (i_source_id),
        .i_dest_key      (i_dest_key),
        .i_src_value     (i_src_value),
        .i_stream_empty  (i_stream_empty),
        .o_result_strobe (o_result_strobe),
        .o_edge_valid    (o_edge_valid),
        .o_out_key       (o_out_key),
        .o_out_value     (o_out_value),
        .o_refill_source (o_refill_source),
        .o_merge_done    (o_merge_done)
    );

`ifndef NO_ASSERTIONS
    // A result never follows another in the next cycle.
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |=> !o_result_strobe)
        else $error("result strobe held for more than one cycle");

    // An edge and a done mark are never given together.
    a_edge_or_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> !(o_edge_valid && o_merge_done))
        else $error("result carries both an edge and a done mark");

    // A transfer always starts work on the item.
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("transfer accepted without the block going busy");
`endif

endmodule
`default_nettype wire

// ----- test/heap_k_way_merge_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heap_k_way_merge_tb: self-checking bench for the heap k-way merge
// A queue-fed driver offers one edge per transfer. The first transfers fill
// the heap and the rest are sorted stream data, with some noise and early
// end-of-stream marks. A tracking model of the heap predicts every popped
// edge and done mark, and a monitor compares each strobe against it.
// num_sources is rewritten, and read back, between phases of sender gaps.
// ----------------------------------------------------------------------------
module heap_k_way_merge_tb;

    import hkm_pkg::*;

    localparam int LIMIT_CYCLES = 300000;
    localparam int SETTLE_CYCLES = 20;
    localparam logic [ADDR_W-1:0] NS_ADDR = ADDR_W'(4 * REG_NUM_SOURCES);

    typedef struct packed {
        logic [SRC_W-1:0]   src_id;
        logic [FIELD_W-1:0] key;
        logic [FIELD_W-1:0] value;
        logic               empty;
    } t_edge_in;

    typedef struct packed {
        logic               edge_valid;
        logic [FIELD_W-1:0] key;
        logic [FIELD_W-1:0] value;
        logic [SRC_W-1:0]   src;
        logic               done;
    } t_merge_out;

    typedef struct packed {
        t_entry [MAX_SOURCES-1:0] slot;
        logic [7:0]               count;
        logic [7:0]               fill_cnt;
        logic [7:0]               active;
        logic                     filling;
        logic [NS_W-1:0]          ns;
    } t_heap_state;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [SRC_W-1:0] i_source_id = '0;
    logic [FIELD_W-1:0] i_dest_key = '0;
    logic [FIELD_W-1:0] i_src_value = '0;
    logic i_stream_empty = 1'b0;
    logic o_result_strobe;
    logic o_edge_valid;
    logic [FIELD_W-1:0] o_out_key;
    logic [FIELD_W-1:0] o_out_value;
    logic [SRC_W-1:0] o_refill_source;
    logic o_merge_done;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    // tracked follows accepted transfers; planned runs ahead while stimulus
    // is generated, so that each stream is refilled when the heap asks for it.
    t_heap_state tracked;
    t_heap_state planned;
    t_edge_in pending_edges[$];
    t_merge_out expected_pops[$];
    t_edge_in driven_edge;
    int refill_due[$];
    logic [FIELD_W-1:0] stream_tail_key[MAX_SOURCES];
    int stream_left[MAX_SOURCES];
    logic merge_over = 1'b0;
    int gap_pct = 0;
    int n_errors = 0;
    int cycle_cnt = 0;

    heap_k_way_merge DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_source_id(i_source_id),
        .i_dest_key(i_dest_key),
        .i_src_value(i_src_value),
        .i_stream_empty(i_stream_empty),
        .o_result_strobe(o_result_strobe),
        .o_edge_valid(o_edge_valid),
        .o_out_key(o_out_key),
        .o_out_value(o_out_value),
        .o_refill_source(o_refill_source),
        .o_merge_done(o_merge_done),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void heap_insert(inout t_heap_state st, input t_entry e);
        int pos;
        int up;
        if (st.count >= MAX_SOURCES) begin
            return;
        end
        pos = int'(st.count);
        st.count = st.count + 8'd1;
        while (pos > 0) begin
            up = (pos - 1) / 2;
            if (!(e.key < st.slot[IDX_W'(up)].key)) begin
                break;
            end
            st.slot[IDX_W'(pos)] = st.slot[IDX_W'(up)];
            pos = up;
        end
        st.slot[IDX_W'(pos)] = e;
    endfunction

    // One accepted edge: returns 1 when it yields a popped edge or a done mark.
    function automatic logic merge_step(inout t_heap_state st, input t_edge_in it,
                                        output t_merge_out res);
        int eff;
        int i;
        int l;
        int r;
        int s;
        t_entry e;
        t_entry tmp;
        res = '0;
        eff = int'(st.ns);
        if (eff < 1) begin
            eff = 1;
        end
        if (eff > MAX_SOURCES) begin
            eff = MAX_SOURCES;
        end
        e.key = it.key[KEY_BITS-1:0];
        e.value = it.value;
        e.src = it.src_id;
        if (st.filling) begin
            if (!it.empty) begin
                heap_insert(st, e);
                if (st.active < MAX_SOURCES) begin
                    st.active = st.active + 8'd1;
                end
            end
            if (st.fill_cnt < MAX_SOURCES) begin
                st.fill_cnt = st.fill_cnt + 8'd1;
            end
            if (st.fill_cnt < eff) begin
                return 1'b0;
            end
            st.filling = 1'b0;
        end else if (it.empty) begin
            if (st.active > 0) begin
                st.active = st.active - 8'd1;
            end
        end else begin
            heap_insert(st, e);
        end
        if (st.count == 0) begin
            res.done = 1'b1;
            return 1'b1;
        end
        res.edge_valid = 1'b1;
        res.key = st.slot[0].key;
        res.value = st.slot[0].value;
        res.src = st.slot[0].src;
        st.count = st.count - 8'd1;
        st.slot[0] = st.slot[IDX_W'(st.count)];
        i = 0;
        while (1) begin
            l = 2 * i + 1;
            r = 2 * i + 2;
            s = i;
            if (l < st.count && st.slot[IDX_W'(l)].key < st.slot[IDX_W'(i)].key) begin
                s = l;
            end
            if (r < st.count && st.slot[IDX_W'(r)].key < st.slot[IDX_W'(s)].key) begin
                s = r;
            end
            if (s == i) begin
                break;
            end
            tmp = st.slot[IDX_W'(i)];
            st.slot[IDX_W'(i)] = st.slot[IDX_W'(s)];
            st.slot[IDX_W'(s)] = tmp;
            i = s;
        end
        return 1'b1;
    endfunction

    // Driver: a transfer completes at an edge where start is high and busy low.
    always @(posedge i_clk) begin : drive_p
        logic taken;
        t_merge_out res;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            taken = start && !busy;
            if (taken && merge_step(tracked, driven_edge, res)) begin
                expected_pops = {expected_pops, res};
            end
            if (!start || taken) begin
                if (pending_edges.size() != 0 && $urandom_range(99) >= gap_pct) begin
                    driven_edge = pending_edges.pop_front();
                    start <= 1'b1;
                    i_source_id <= driven_edge.src_id;
                    i_dest_key <= driven_edge.key;
                    i_src_value <= driven_edge.value;
                    i_stream_empty <= driven_edge.empty;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : monitor_p
        t_merge_out got;
        t_merge_out want;
        if (i_rst_n && o_result_strobe) begin
            got = {o_edge_valid, o_out_key, o_out_value, o_refill_source, o_merge_done};
            if (expected_pops.size() == 0) begin
                $display("%0t: unexpected result valid=%0b key=%h value=%h refill=%0d done=%0b",
                         $time, got.edge_valid, got.key, got.value, got.src, got.done);
                n_errors++;
            end else begin
                want = expected_pops.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch, expected valid=%0b key=%h value=%h refill=%0d done=%0b",
                             $time, want.edge_valid, want.key, want.value, want.src, want.done);
                    $display("%0t:           actual valid=%0b key=%h value=%h refill=%0d done=%0b",
                             $time, got.edge_valid, got.key, got.value, got.src, got.done);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("heap_k_way_merge_tb: done, errors");
            $finish;
        end
    end

    // Queues an edge and advances the planning copy, noting which stream the
    // heap will ask for next.
    task automatic queue_edge(input t_edge_in it);
        t_merge_out res;
        if (merge_step(planned, it, res)) begin
            if (res.done) begin
                merge_over = 1'b1;
            end else begin
                refill_due = {refill_due, int'(res.src)};
            end
        end
        pending_edges = {pending_edges, it};
    endtask

    task automatic queue_fill(input int src, input logic [FIELD_W-1:0] key, input int left);
        t_edge_in it;
        it.src_id = SRC_W'(src);
        it.key = key;
        it.value = $urandom;
        it.empty = (left < 0);
        stream_tail_key[src] = key;
        stream_left[src] = (left < 0) ? 0 : left;
        queue_edge(it);
    endtask

    task automatic wait_idle();
        while (pending_edges.size() != 0 || start || expected_pops.size() != 0 || busy) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_num_sources(input logic [NS_W-1:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= NS_ADDR;
        pwdata <= DATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tracked.ns = val;
        planned.ns = val;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== DATA_W'(val)) begin
            $display("%0t: num_sources read back, expected %h actual %h", $time,
                     DATA_W'(val), prdata);
            n_errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Mostly the stream the heap asked for, with its next sorted edge or its
    // end mark; now and then a stray edge from any stream with any key.
    task automatic make_items(input int n);
        t_edge_in it;
        int s;
        int noise_pct;
        repeat (n) begin
            noise_pct = (merge_over || refill_due.size() == 0) ? 100 : 8;
            if ($urandom_range(99) < noise_pct) begin
                it.src_id = SRC_W'($urandom_range(MAX_SOURCES - 1));
                it.key = $urandom_range(1) ? $urandom : $urandom_range(300);
                it.value = $urandom;
                it.empty = merge_over ? ($urandom_range(99) < 40) : ($urandom_range(7) == 0);
            end else begin
                s = refill_due.pop_front();
                it.src_id = SRC_W'(s);
                it.value = $urandom;
                if (stream_left[s] == 0) begin
                    it.empty = 1'b1;
                    it.key = $urandom;
                end else begin
                    stream_tail_key[s] = stream_tail_key[s] + $urandom_range(3);
                    stream_left[s]--;
                    it.empty = 1'b0;
                    it.key = stream_tail_key[s];
                end
            end
            queue_edge(it);
        end
    endtask

    initial begin : stimulus_p
        int phase_gap[4];
        logic [NS_W-1:0] phase_ns[4];
        phase_gap = '{0, 55, 0, 16};
        phase_ns = '{NS_W'(1), NS_W'($urandom_range(31)), NS_RESET,
                     NS_W'($urandom_range(2, 15))};
        tracked = '0;
        tracked.filling = 1'b1;
        tracked.ns = NS_RESET;
        planned = tracked;
        for (int k = 0; k < MAX_SOURCES; k++) begin
            stream_tail_key[k] = '0;
            stream_left[k] = 0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Fill with an out-of-range count first; the largest key stays at the
        // bottom of the heap until the very end, and equal keys test tie order.
        gap_pct = 30;
        write_num_sources(NS_W'(31));
        queue_fill(0, '1, 0);
        queue_fill(1, '0, $urandom_range(50, 90));
        queue_fill(2, $urandom, -1);
        queue_fill(3, 10, $urandom_range(50, 90));
        queue_fill(4, 10, $urandom_range(50, 90));
        queue_fill(5, 9, $urandom_range(50, 90));
        queue_fill(6, 10, $urandom_range(50, 90));
        wait_idle();
        write_num_sources(NS_RESET);
        queue_fill(7, 10, $urandom_range(50, 90));
        queue_fill(8, 12, $urandom_range(50, 90));
        queue_fill(9, 10, $urandom_range(50, 90));
        queue_fill(10, 11, $urandom_range(50, 90));
        queue_fill(11, 9, $urandom_range(50, 90));
        queue_fill(12, 10, $urandom_range(50, 90));
        queue_fill(13, 15, $urandom_range(50, 90));
        wait_idle();
        // A zero count mid-fill ends the fill phase on the very next transfer.
        write_num_sources('0);
        queue_fill(14, 10, $urandom_range(50, 90));

        for (int p = 0; p < 4; p++) begin
            wait_idle();
            write_num_sources(phase_ns[p]);
            gap_pct = phase_gap[p];
            make_items(260);
        end

        while (pending_edges.size() != 0 || start || expected_pops.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (30) @(posedge i_clk);
        if (n_errors == 0 && expected_pops.size() == 0) begin
            $display("heap_k_way_merge_tb: done, clean");
        end else begin
            $display("heap_k_way_merge_tb: done, errors");
        end
        $finish;
    end

endmodule
